/* rtl/sha256_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Word and hash-state types, initial hash values and the round constant table.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Eight 32-bit words, index 0 is the first (a / H0).
  typedef word_t [0:7] vars_t;

  localparam vars_t H_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

/* rtl/sha256_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule step, shared by all 64
// rounds of every block.
// ----------------------------------------------------------------------------
module sha256_round
  import sha256_pkg::*;
(
  input  vars_t v,        // working variables a..h
  input  word_t k,        // round constant
  input  word_t w0,       // schedule word used in this round, w[t]
  input  word_t w1,       // w[t+1]
  input  word_t w9,       // w[t+9]
  input  word_t w14,      // w[t+14]
  output vars_t v_next,
  output word_t w_new     // w[t+16]
);

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  word_t big_s0;
  word_t big_s1;
  word_t ch;
  word_t maj;
  word_t t1;
  word_t t2;
  word_t small_s0;
  word_t small_s1;

  always_comb begin
    big_s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    big_s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + big_s1 + ch + k + w0;
    t2     = big_s0 + maj;

    v_next    = v;
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;

    small_s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    small_s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new    = w0 + small_s0 + w9 + small_s1;
  end

endmodule

/* rtl/sha256_message_digest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Hashes a byte stream and returns the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one message byte per transfer in tdata, tlast
//   on the final byte. A transfer with tuser set carries no byte and closes
//   the message (a zero-length message if nothing came before it).
//   The output stream returns eight 32-bit digest words, word 0 first, with
//   the word index in tdata, tlast on the eighth word and tuser set when
//   the 61-bit byte count saturated during the message.
// Operation:
//   Bytes are taken while the input is ready. The 64th byte of a block
//   starts the round unit, which runs 64 rounds and then the hash update.
//   Closing a message takes a padding step and then the rounds and hash
//   update for each padded block (one or two), then the eight words follow
//   at one per accepted transfer.
//   The input is not ready while the round unit runs or words are pending.
// Reset and stall:
//   Reset loads the initial hash and clears the byte count. A stalled
//   receiver holds the current word; the block waits for it indefinitely.
// ----------------------------------------------------------------------------
module sha256_message_digest
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // empty_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast,   // last_word
  output logic        m_axis_tuser    // length_overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FINISH,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_BLOCK,
    PH_PAD,
    PH_FINAL
  } phase_t;

  localparam logic [60:0] COUNT_MAX = '1;

  state_t      state;
  phase_t      phase;
  word_t       blk [16];
  vars_t       vars;
  vars_t       hash;
  vars_t       sum;
  vars_t       rnd_vars;
  word_t       w_new;
  logic [60:0] byte_count;
  logic [5:0]  fill_pos;
  logic [5:0]  round_cnt;
  logic [2:0]  out_idx;
  logic        overflow_seen;
  logic        finish_pending;
  logic [7:0]  put_val;
  word_t       put_word;
  logic [63:0] bit_len;
  logic        s_fire;
  logic        m_fire;

  sha256_round u_round (
    .v      (vars),
    .k      (round_k(round_cnt)),
    .w0     (blk[0]),
    .w1     (blk[1]),
    .w9     (blk[9]),
    .w14    (blk[14]),
    .v_next (rnd_vars),
    .w_new  (w_new)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum[i] = hash[i] + vars[i];
    end
    // Byte merge into the word at the fill position, big-endian within the word.
    put_val  = (state == S_FINISH) ? 8'h80 : s_axis_tdata;
    put_word = ((fill_pos[1:0] == 2'd0) ? word_t'(0) : blk[fill_pos[5:2]])
             | (word_t'(put_val) << {~fill_pos[1:0], 3'b000});
    bit_len  = {byte_count, 3'b000};
  end

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {5'b00000, out_idx, hash[out_idx]};
  assign m_axis_tlast  = (out_idx == 3'd7);
  assign m_axis_tuser  = overflow_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_BLOCK;
      hash           <= H_INIT;
      byte_count     <= '0;
      fill_pos       <= '0;
      round_cnt      <= '0;
      out_idx        <= '0;
      overflow_seen  <= 1'b0;
      finish_pending <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            if (!s_axis_tuser) begin
              blk[fill_pos[5:2]] <= put_word;
              if (byte_count == COUNT_MAX) begin
                overflow_seen <= 1'b1;
              end else begin
                byte_count <= byte_count + 61'd1;
              end
              fill_pos <= fill_pos + 6'd1;
              if (fill_pos == 6'd63) begin
                vars           <= hash;
                round_cnt      <= '0;
                phase          <= PH_BLOCK;
                finish_pending <= s_axis_tlast;
                state          <= S_ROUND;
              end else if (s_axis_tlast) begin
                state <= S_FINISH;
              end
            end else begin
              state <= S_FINISH;
            end
          end
        end

        S_FINISH: begin
          // Pad marker at the fill position, zeros after it, and the length
          // in the last two words when it still fits in this block.
          for (int j = 0; j < 16; j++) begin
            if (4'(j) == fill_pos[5:2]) begin
              blk[j] <= put_word;
            end else if (4'(j) > fill_pos[5:2] && (j < 14 || fill_pos >= 6'd56)) begin
              blk[j] <= '0;
            end
          end
          if (fill_pos >= 6'd56) begin
            phase <= PH_PAD;
          end else begin
            blk[14] <= bit_len[63:32];
            blk[15] <= bit_len[31:0];
            phase   <= PH_FINAL;
          end
          vars      <= hash;
          round_cnt <= '0;
          state     <= S_ROUND;
        end

        S_ROUND: begin
          vars <= rnd_vars;
          for (int j = 0; j < 15; j++) begin
            blk[j] <= blk[j + 1];
          end
          blk[15]   <= w_new;
          round_cnt <= round_cnt + 6'd1;
          if (round_cnt == 6'd63) begin
            state <= S_ADD;
          end
        end

        S_ADD: begin
          hash <= sum;
          case (phase)
            PH_BLOCK: begin
              finish_pending <= 1'b0;
              state          <= finish_pending ? S_FINISH : S_IDLE;
            end
            PH_PAD: begin
              // Length-only block after a pad that overran the first one.
              for (int j = 0; j < 14; j++) begin
                blk[j] <= '0;
              end
              blk[14]   <= bit_len[63:32];
              blk[15]   <= bit_len[31:0];
              vars      <= sum;
              round_cnt <= '0;
              phase     <= PH_FINAL;
              state     <= S_ROUND;
            end
            PH_FINAL: begin
              out_idx <= '0;
              state   <= S_OUT;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        S_OUT: begin
          if (m_fire) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              hash          <= H_INIT;
              byte_count    <= '0;
              fill_pos      <= '0;
              overflow_seen <= 1'b0;
              phase         <= PH_BLOCK;
              state         <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The input side is closed while digest words are being delivered.
  a_no_input_while_output: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while digest words pending");

  // The round unit always runs exactly 64 rounds before the hash update.
  a_rounds_end_in_add: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round_cnt == 6'd63) |=> (state == S_ADD))
    else $error("round sequence did not end in hash update");

  // An empty-message transfer always leads straight to padding.
  a_empty_pads: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tuser) |=> (state == S_FINISH))
    else $error("empty-message transfer did not start padding");

  // After the eighth word the message state is back at its reset value.
  a_clean_after_digest: assert property (@(posedge clk) disable iff (rst)
    (m_fire && m_axis_tlast) |=>
      (fill_pos == 6'd0 && byte_count == 61'd0 && !overflow_seen && s_axis_tready))
    else $error("message state not cleared after digest");

endmodule

/* test/tb_sha256_message_digest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest testbench
// Streams whole messages into the hasher one byte per transfer. A local
// SHA-256 model, fed by every accepted input transfer, queues the eight
// digest words that each closed message should return. Every output
// transfer is checked against them in order. Both stream sides idle or
// stall in random bursts, and the final stretch of the run has none.
// ----------------------------------------------------------------------------
module tb_sha256_message_digest
  import sha256_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 200;

  localparam logic [0:7][31:0] IV_WORDS = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_message;
  } msg_item_t;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
    logic       length_overflow;
  } digest_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0; // last_byte
  logic        s_axis_tuser = 1'b0; // empty_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] digest_word, [34:32] word_index
  logic        m_axis_tlast;        // last_word
  logic        m_axis_tuser;        // length_overflow

  sha256_message_digest uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local hash state, mirroring what the block should hold.
  word_t       hash_state [8];
  word_t       block_buf [16];
  logic [60:0] msg_bytes;
  logic [5:0]  fill_pos;
  bit          count_sat;

  msg_item_t   pending_items [$];
  digest_out_t expected_words [$];

  int total_items    = 0;
  int sent_items     = 0;
  int accepted_items = 0;
  int fail_count     = 0;
  int cycle_cnt      = 0;
  int in_gap         = 0;
  int out_stall      = 0;
  bit in_fire        = 1'b0;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_digest();
    for (int i = 0; i < 8; i++) hash_state[i] = IV_WORDS[i];
    for (int i = 0; i < 16; i++) block_buf[i] = '0;
    msg_bytes = '0;
    fill_pos  = '0;
    count_sat = 1'b0;
  endfunction

  function automatic void compress_block();
    word_t w [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  // Bytes go in big-endian; the first byte of a word clears it.
  function automatic void place_byte(logic [5:0] pos, logic [7:0] b);
    if (pos[1:0] == 2'd0) block_buf[pos[5:2]] = '0;
    block_buf[pos[5:2]] = block_buf[pos[5:2]] | (word_t'(b) << (24 - 8 * pos[1:0]));
  endfunction

  function automatic void sha_absorb_item(logic [7:0] data, logic last, logic empty);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    digest_out_t res;
    if (!empty) begin
      place_byte(fill_pos, data);
      // The byte count saturates rather than wrapping.
      if (msg_bytes == '1) count_sat = 1'b1;
      else msg_bytes = msg_bytes + 61'd1;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) compress_block();
    end
    if (empty || last) begin
      pos = fill_pos;
      place_byte(pos, 8'h80);
      for (int i = pos[5:2] + 1; i < 16; i++) block_buf[i] = '0;
      // No room for the length field, so pad out a further block.
      if (pos >= 6'd56) begin
        compress_block();
        for (int i = 0; i < 16; i++) block_buf[i] = '0;
      end
      bit_len = {msg_bytes, 3'b000};
      block_buf[14] = bit_len[63:32];
      block_buf[15] = bit_len[31:0];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        res.digest_word     = hash_state[i];
        res.word_index      = 3'(i);
        res.last_word       = (i == 7);
        res.length_overflow = count_sat;
        expected_words.push_back(res);
      end
      restart_digest();
    end
  endfunction

  function automatic void push_item(logic [7:0] data, logic last, logic empty);
    msg_item_t it;
    it.data_byte     = data;
    it.last_byte     = last;
    it.empty_message = empty;
    pending_items.push_back(it);
  endfunction

  // A message of len random bytes, closed by tlast on the final byte or
  // by a separate empty-message transfer with random ignored fields.
  function automatic void queue_message(int len, bit close_by_empty);
    for (int k = 0; k < len; k++)
      push_item(8'($urandom_range(0, 255)), (k == len - 1) && !close_by_empty, 1'b0);
    if (len == 0 || close_by_empty)
      push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endfunction

  // Inputs change on the falling edge only.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_fire) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (sent_items * 5 < total_items * 4 && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 8) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          {s_axis_tdata, s_axis_tlast, s_axis_tuser} <= pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          sent_items++;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else if (sent_items * 5 < total_items * 4 && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(1, 8) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    digest_out_t exp_w;
    cycle_cnt++;
    in_fire = !rst && s_axis_tvalid && (s_axis_tready === 1'b1);
    if (in_fire) begin
      sha_absorb_item(s_axis_tdata, s_axis_tlast, s_axis_tuser);
      accepted_items++;
    end
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("digest word %h arrived with none expected", m_axis_tdata[31:0]);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (m_axis_tdata[31:0] !== exp_w.digest_word) begin
          $error("digest_word: expected %h, got %h", exp_w.digest_word, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[34:32] !== exp_w.word_index) begin
          $error("word_index: expected %0d, got %0d", exp_w.word_index, m_axis_tdata[34:32]);
          fail_count++;
        end
        if (m_axis_tlast !== exp_w.last_word) begin
          $error("last_word: expected %b, got %b", exp_w.last_word, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== exp_w.length_overflow) begin
          $error("length_overflow: expected %b, got %b", exp_w.length_overflow, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int len;
    int start_size;
    restart_digest();

    // Empty message, then again with the ignored fields set.
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    // Single-byte messages at both extremes of the byte.
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    // "abc"
    push_item(8'h61, 1'b0, 1'b0);
    push_item(8'h62, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b0);
    // Unmarked bytes closed by an empty-message transfer.
    push_item(8'h80, 1'b0, 1'b0);
    push_item(8'h7f, 1'b0, 1'b0);
    push_item(8'h5a, 1'b1, 1'b1);
    queue_message(5, 1'b0);

    start_size = pending_items.size();
    // Fifty-six bytes forces the length field into a second padded block.
    queue_message(56, 1'b0);
    while (pending_items.size() - start_size < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1, 2, 3: len = $urandom_range(1, 8);
        4, 5: begin
          case ($urandom_range(0, 5))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            default: len = 65;
          endcase
        end
        default: len = $urandom_range(9, 70);
      endcase
      queue_message(len, $urandom_range(0, 3) == 0);
    end
    total_items = pending_items.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (accepted_items == total_items);
    wait (expected_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d digest words never arrived", expected_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
